// ----- hw/rtl/dfbp_pkg.sv -----
// Shared types and constants of the detector frame byte parser.
// No dependencies.
package dfbp_pkg;

  localparam int NumPixelsDef = 64;
  localparam int UnitBytesDef = 4;
  localparam int QueueDepth   = 4;

  localparam logic [7:0] TypePix  = 8'hd5;
  localparam logic [7:0] TypePed  = 8'hd4;
  localparam int         HdrBytes = 20;
  localparam int         SkipBias = 7;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StBelow    = 3'd1;
  localparam logic [2:0] StUnhandled = 3'd2;
  localparam logic [2:0] StCount    = 3'd3;
  localparam logic [2:0] StBadSkip  = 3'd4;
  localparam logic [2:0] StOverflow = 3'd5;

  localparam logic KindSample = 1'b0;
  localparam logic KindStatus = 1'b1;

  localparam logic CfgMinEvent = 1'b0;
  localparam logic CfgAcceptPed = 1'b1;

  typedef struct packed {
    logic        result_kind;
    logic [5:0]  pixel_index;
    logic [15:0] sample_value;
    logic [31:0] packet_time;
    logic [7:0]  source_id;
    logic [7:0]  channel_id;
    logic [31:0] event_number;
    logic        packet_kind;
    logic [2:0]  frame_status;
    logic        last_of_frame;
  } result_t;

  typedef struct packed {
    logic       wr_en;
    logic       index;
    logic [31:0] data;
  } cfg_t;

  function automatic logic [5:0] pixel_map(input logic [5:0] i);
    logic [5:0] m;
    unique case (i)
      6'd0: m = 6'd31; 6'd1: m = 6'd30; 6'd2: m = 6'd29; 6'd3: m = 6'd28;
      6'd4: m = 6'd23; 6'd5: m = 6'd22; 6'd6: m = 6'd21; 6'd7: m = 6'd20;
      6'd8: m = 6'd15; 6'd9: m = 6'd14; 6'd10: m = 6'd13; 6'd11: m = 6'd12;
      6'd12: m = 6'd7; 6'd13: m = 6'd6; 6'd14: m = 6'd5; 6'd15: m = 6'd4;
      6'd16: m = 6'd0; 6'd17: m = 6'd1; 6'd18: m = 6'd2; 6'd19: m = 6'd3;
      6'd20: m = 6'd8; 6'd21: m = 6'd9; 6'd22: m = 6'd10; 6'd23: m = 6'd11;
      6'd24: m = 6'd16; 6'd25: m = 6'd17; 6'd26: m = 6'd18; 6'd27: m = 6'd19;
      6'd28: m = 6'd24; 6'd29: m = 6'd25; 6'd30: m = 6'd26; 6'd31: m = 6'd27;
      6'd32: m = 6'd63; 6'd33: m = 6'd62; 6'd34: m = 6'd61; 6'd35: m = 6'd60;
      6'd36: m = 6'd55; 6'd37: m = 6'd54; 6'd38: m = 6'd53; 6'd39: m = 6'd52;
      6'd40: m = 6'd47; 6'd41: m = 6'd46; 6'd42: m = 6'd45; 6'd43: m = 6'd44;
      6'd44: m = 6'd39; 6'd45: m = 6'd38; 6'd46: m = 6'd37; 6'd47: m = 6'd36;
      6'd48: m = 6'd32; 6'd49: m = 6'd33; 6'd50: m = 6'd34; 6'd51: m = 6'd35;
      6'd52: m = 6'd40; 6'd53: m = 6'd41; 6'd54: m = 6'd42; 6'd55: m = 6'd43;
      6'd56: m = 6'd48; 6'd57: m = 6'd49; 6'd58: m = 6'd50; 6'd59: m = 6'd51;
      6'd60: m = 6'd56; 6'd61: m = 6'd57; 6'd62: m = 6'd58; 6'd63: m = 6'd59;
      default: m = 6'd0;
    endcase
    return m;
  endfunction

endpackage

// ----- hw/rtl/dfbp_if.sv -----
// Stream channels of the detector frame byte parser.
// No dependencies.
interface dfbp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface dfbp_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [5:0]  pixel_index;
  logic [15:0] sample_value;
  logic [31:0] packet_time;
  logic [7:0]  source_id;
  logic [7:0]  channel_id;
  logic [31:0] event_number;
  logic        packet_kind;
  logic [2:0]  frame_status;
  logic        last_of_frame;
  modport source (output valid, output result_kind, output pixel_index, output sample_value,
                  output packet_time, output source_id, output channel_id,
                  output event_number, output packet_kind, output frame_status,
                  output last_of_frame, input ready);
  modport sink (input valid, input result_kind, input pixel_index, input sample_value,
                input packet_time, input source_id, input channel_id,
                input event_number, input packet_kind, input frame_status,
                input last_of_frame, output ready);
endinterface

// ----- hw/rtl/dfbp_parser.sv -----
// Front part: frame byte parser, one byte per transfer, up to two results.
// Depends on dfbp_pkg.
module dfbp_parser #(
  parameter int NUM_PIXELS = dfbp_pkg::NumPixelsDef,
  parameter int UNIT_BYTES = dfbp_pkg::UnitBytesDef
) (
  input  logic              clk,
  input  logic              rst,
  input  dfbp_pkg::cfg_t    cfg,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  output logic [1:0]        push_count,
  output dfbp_pkg::result_t res0,
  output dfbp_pkg::result_t res1
);
  import dfbp_pkg::*;

  localparam int OffW = 24 + $clog2(UNIT_BYTES) + 2;

  localparam logic [4:0] PH_HDR = 5'd0, PH_SKIP = 5'd1, PH_DBLEN = 5'd2, PH_VER = 5'd3,
    PH_TYPE = 5'd4, PH_SEQ = 5'd5, PH_TIME = 5'd6, PH_DLEN = 5'd7, PH_P_SRC = 5'd8,
    PH_P_TRIG = 5'd9, PH_P_CHAN = 5'd10, PH_P_HOLD = 5'd11, PH_P_NS = 5'd12,
    PH_P_SMP = 5'd13, PH_E_NEV = 5'd14, PH_E_NS = 5'd15, PH_E_TIME = 5'd16,
    PH_E_TRIG = 5'd17, PH_E_SRC = 5'd18, PH_E_CHAN = 5'd19, PH_E_SMP = 5'd20,
    PH_A_LEN = 5'd21, PH_A_SKIP = 5'd22, PH_T_LEN = 5'd23, PH_T_SKIP = 5'd24,
    PH_DONE = 5'd25;

  logic [31:0] min_event_number;
  logic        accept_pedestal_packets;

  logic [4:0]      phase, phase_next;
  logic [OffW-1:0] off;
  logic [23:0]     flen, flen_next;
  logic [15:0]     hlen, hlen_next;
  logic [31:0]     shift, shift_next;
  logic [2:0]      fbc, fbc_next;
  logic [31:0]     evnum, evnum_next;
  logic [7:0]      ptype, ptype_next;
  logic [31:0]     ptime, ptime_next;
  logic [7:0]      src, src_next;
  logic [7:0]      chan, chan_next;
  logic [15:0]     nexp, nexp_next;
  logic [15:0]     cnt, cnt_next;
  logic [7:0]      left, left_next;
  logic [2:0]      pend, pend_next;

  logic [OffW-1:0] off_inc, target, frame_end;
  logic            done2, done4, smp_out, frame_over;
  logic [5:0]      smp_pix;
  logic [15:0]     cnt_inc;
  logic [7:0]      left_dec;
  logic [2:0]      st;

  assign off_inc  = off + OffW'(1);
  assign target   = OffW'((OffW'(hlen) + OffW'(SkipBias)) * OffW'(UNIT_BYTES));
  assign shift_next = (fbc == 3'd0) ? {24'd0, data_byte} : {shift[23:0], data_byte};
  assign done2    = (fbc >= 3'd1);
  assign done4    = (fbc >= 3'd3);
  assign cnt_inc  = cnt + 16'd1;
  assign left_dec = left - 8'd1;

  always_comb begin
    frame_end = OffW'(OffW'(flen) * OffW'(UNIT_BYTES));
    if (frame_end < OffW'(HdrBytes)) begin
      frame_end = OffW'(HdrBytes);
    end
  end

  always_comb begin
    phase_next = phase; flen_next = flen; hlen_next = hlen; fbc_next = fbc;
    evnum_next = evnum; ptype_next = ptype; ptime_next = ptime; src_next = src;
    chan_next = chan; nexp_next = nexp; cnt_next = cnt; left_next = left;
    pend_next = pend; smp_out = 1'b0; smp_pix = 6'd0;
    unique case (phase)
      PH_HDR: begin
        if (off == OffW'(0)) begin
          pend_next = StOk;
          fbc_next = 3'd0;
        end else if (off == OffW'(1)) begin
          flen_next = {16'd0, data_byte};
        end else if (off <= OffW'(3)) begin
          flen_next = {flen[15:0], data_byte};
        end else if (off == OffW'(8)) begin
          hlen_next = {8'd0, data_byte};
        end else if (off == OffW'(9)) begin
          hlen_next = {hlen[7:0], data_byte};
        end else if (off == OffW'(16)) begin
          evnum_next = {24'd0, data_byte};
        end else if (off >= OffW'(17) && off <= OffW'(19)) begin
          evnum_next = {evnum[23:0], data_byte};
        end
        if (off >= OffW'(19)) begin
          if (evnum_next <= min_event_number) begin
            if (pend_next == StOk) pend_next = StBelow;
            phase_next = PH_DONE;
          end else if (target < OffW'(HdrBytes)) begin
            if (pend_next == StOk) pend_next = StBadSkip;
            phase_next = PH_DONE;
          end else begin
            phase_next = (target == OffW'(HdrBytes)) ? PH_DBLEN : PH_SKIP;
          end
        end
      end
      PH_SKIP: if (off_inc >= target) phase_next = PH_DBLEN;
      PH_DBLEN: begin
        fbc_next = done4 ? 3'd0 : fbc + 3'd1;
        if (done4) phase_next = PH_VER;
      end
      PH_VER: phase_next = PH_TYPE;
      PH_TYPE: begin
        ptype_next = data_byte;
        phase_next = PH_SEQ;
      end
      PH_SEQ: begin
        fbc_next = done2 ? 3'd0 : fbc + 3'd1;
        if (done2) phase_next = PH_TIME;
      end
      PH_TIME: begin
        fbc_next = done4 ? 3'd0 : fbc + 3'd1;
        if (done4) begin
          ptime_next = shift_next;
          phase_next = PH_DLEN;
        end
      end
      PH_DLEN: begin
        fbc_next = done2 ? 3'd0 : fbc + 3'd1;
        if (done2) begin
          if (ptype == TypePix) begin
            phase_next = PH_P_SRC;
          end else if (ptype == TypePed && accept_pedestal_packets) begin
            phase_next = PH_E_NEV;
          end else begin
            if (pend == StOk) pend_next = StUnhandled;
            phase_next = PH_A_LEN;
          end
        end
      end
      PH_P_SRC: begin
        src_next = data_byte;
        phase_next = PH_P_TRIG;
      end
      PH_P_TRIG: phase_next = PH_P_CHAN;
      PH_P_CHAN: begin
        chan_next = data_byte;
        phase_next = PH_P_HOLD;
      end
      PH_P_HOLD: begin
        fbc_next = done2 ? 3'd0 : fbc + 3'd1;
        if (done2) phase_next = PH_P_NS;
      end
      PH_P_NS: begin
        fbc_next = done2 ? 3'd0 : fbc + 3'd1;
        if (done2) begin
          nexp_next = shift_next[15:0];
          cnt_next = 16'd0;
          if (shift_next[15:0] == 16'(NUM_PIXELS)) begin
            phase_next = PH_P_SMP;
          end else begin
            if (pend == StOk) pend_next = StCount;
            phase_next = PH_A_LEN;
          end
        end
      end
      PH_P_SMP: begin
        fbc_next = done2 ? 3'd0 : fbc + 3'd1;
        if (done2) begin
          smp_out = 1'b1;
          smp_pix = pixel_map(cnt[5:0]);
          cnt_next = cnt_inc;
          if (cnt_inc >= 16'(NUM_PIXELS)) phase_next = PH_A_LEN;
        end
      end
      PH_E_NEV: begin
        left_next = data_byte;
        phase_next = PH_E_NS;
      end
      PH_E_NS: begin
        fbc_next = done2 ? 3'd0 : fbc + 3'd1;
        if (done2) begin
          nexp_next = shift_next[15:0];
          phase_next = (left == 8'd0) ? PH_A_LEN : PH_E_TIME;
        end
      end
      PH_E_TIME: begin
        fbc_next = done4 ? 3'd0 : fbc + 3'd1;
        if (done4) phase_next = PH_E_TRIG;
      end
      PH_E_TRIG: phase_next = PH_E_SRC;
      PH_E_SRC: begin
        src_next = data_byte;
        phase_next = PH_E_CHAN;
      end
      PH_E_CHAN: begin
        chan_next = data_byte;
        cnt_next = 16'd0;
        if (nexp == 16'd0) begin
          left_next = left_dec;
          phase_next = (left_dec == 8'd0) ? PH_A_LEN : PH_E_TIME;
        end else begin
          phase_next = PH_E_SMP;
        end
      end
      PH_E_SMP: begin
        fbc_next = done2 ? 3'd0 : fbc + 3'd1;
        if (done2) begin
          if (cnt < 16'(NUM_PIXELS)) begin
            smp_out = 1'b1;
            smp_pix = cnt[5:0];
          end else if (pend == StOk) begin
            pend_next = StOverflow;
          end
          cnt_next = cnt_inc;
          if (cnt_inc == nexp) begin
            left_next = left_dec;
            phase_next = (left_dec == 8'd0) ? PH_A_LEN : PH_E_TIME;
          end
        end
      end
      PH_A_LEN: begin
        left_next = data_byte;
        phase_next = (data_byte == 8'd0) ? PH_T_LEN : PH_A_SKIP;
      end
      PH_A_SKIP: begin
        left_next = left_dec;
        if (left_dec == 8'd0) phase_next = PH_T_LEN;
      end
      PH_T_LEN: begin
        left_next = data_byte;
        phase_next = (data_byte == 8'd0) ? PH_DONE : PH_T_SKIP;
      end
      PH_T_SKIP: begin
        left_next = left_dec;
        if (left_dec == 8'd0) phase_next = PH_DONE;
      end
      default: phase_next = PH_DONE;
    endcase
  end

  assign frame_over = (off >= OffW'(HdrBytes - 1)) && (off_inc >= frame_end);
  assign st = (pend_next == StOk && phase_next != PH_DONE) ? StBadSkip : pend_next;

  always_comb begin
    dfbp_pkg::result_t s, t;
    s = '0;
    s.result_kind = KindSample;
    s.pixel_index = smp_pix;
    s.sample_value = shift_next[15:0];
    s.packet_time = ptime;
    s.source_id = src;
    s.channel_id = chan;
    s.event_number = evnum;
    s.packet_kind = (phase == PH_E_SMP) && (ptype == TypePed);
    t = '0;
    t.result_kind = KindStatus;
    t.event_number = evnum_next;
    t.frame_status = st;
    t.last_of_frame = 1'b1;
    res0 = smp_out ? s : t;
    res1 = t;
    push_count = fire ? (2'(smp_out) + 2'(frame_over)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_event_number <= 32'd10;
      accept_pedestal_packets <= 1'b1;
    end else if (cfg.wr_en) begin
      if (cfg.index == CfgMinEvent) min_event_number <= cfg.data;
      if (cfg.index == CfgAcceptPed) accept_pedestal_packets <= cfg.data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR; off <= '0; flen <= '0; hlen <= '0; shift <= '0; fbc <= '0;
      evnum <= '0; ptype <= '0; ptime <= '0; src <= '0; chan <= '0; nexp <= '0;
      cnt <= '0; left <= '0; pend <= '0;
    end else if (fire) begin
      flen <= flen_next; hlen <= hlen_next; shift <= shift_next; evnum <= evnum_next;
      ptype <= ptype_next; ptime <= ptime_next; src <= src_next; chan <= chan_next;
      nexp <= nexp_next; cnt <= cnt_next; left <= left_next; pend <= pend_next;
      if (frame_over) begin
        phase <= PH_HDR;
        off <= '0;
        fbc <= 3'd0;
      end else begin
        phase <= phase_next;
        off <= off_inc;
        fbc <= fbc_next;
      end
    end
  end

endmodule

// ----- hw/rtl/dfbp_queue.sv -----
// Back part: result queue taking up to two results a cycle, one out a cycle while out_ready is high.
// Depends on dfbp_pkg.
module dfbp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_count,
  input  dfbp_pkg::result_t res0,
  input  dfbp_pkg::result_t res1,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output dfbp_pkg::result_t out_res
);
  import dfbp_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  result_t         mem [QueueDepth];
  logic [PtrW-1:0] wr, rd;
  logic [PtrW:0]   count;
  logic            pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_res   = mem[rd];
  assign room      = (count <= (PtrW+1)'(QueueDepth - 2));

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) mem[wr] <= res0;
    if (push_count == 2'd2) mem[wr + PtrW'(1)] <= res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0;
      rd <= '0;
      count <= '0;
    end else begin
      wr <= wr + PtrW'(push_count);
      if (pop) rd <= rd + PtrW'(1);
      count <= count + (PtrW+1)'(push_count) - (PtrW+1)'(pop);
    end
  end

endmodule

// ----- hw/rtl/detector_frame_byte_parser_unit.sv -----
// Top level of the detector frame byte parser: parser front, result queue back.
// Depends on dfbp_pkg, dfbp_if, dfbp_parser and dfbp_queue.
// Throughput: one byte per cycle; ready holds while the queue has two free slots.
// Results: each is written into the queue on its byte transfer and offered once earlier results are taken.
// Reset: synchronous rst clears parse state and queue; registers return to defaults.
module detector_frame_byte_parser_unit #(
  parameter int NUM_PIXELS = dfbp_pkg::NumPixelsDef,
  parameter int UNIT_BYTES = dfbp_pkg::UnitBytesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  dfbp_byte_if.sink     byte_in,
  dfbp_result_if.source result_out
);
  import dfbp_pkg::*;

  cfg_t       cfg;
  logic       fire, room;
  logic [1:0] push_count;
  result_t    res0, res1, out_res;

  assign cfg = '{wr_en: cfg_wr_en, index: cfg_index, data: cfg_wdata};
  assign byte_in.ready = room;
  assign fire = byte_in.valid && room;

  dfbp_parser #(.NUM_PIXELS(NUM_PIXELS), .UNIT_BYTES(UNIT_BYTES)) u_parser (
    .clk, .rst, .cfg, .fire, .data_byte(byte_in.data_byte), .push_count, .res0, .res1
  );

  dfbp_queue u_queue (
    .clk, .rst, .push_count, .res0, .res1, .room,
    .out_valid(result_out.valid), .out_ready(result_out.ready), .out_res
  );

  assign result_out.result_kind   = out_res.result_kind;
  assign result_out.pixel_index   = out_res.pixel_index;
  assign result_out.sample_value  = out_res.sample_value;
  assign result_out.packet_time   = out_res.packet_time;
  assign result_out.source_id     = out_res.source_id;
  assign result_out.channel_id    = out_res.channel_id;
  assign result_out.event_number  = out_res.event_number;
  assign result_out.packet_kind   = out_res.packet_kind;
  assign result_out.frame_status  = out_res.frame_status;
  assign result_out.last_of_frame = out_res.last_of_frame;

  a_push_needs_fire: assert property (@(posedge clk) disable iff (rst)
    push_count != 2'd0 |-> fire) else $error("results pushed without a byte transfer");
  a_pair_ends_frame: assert property (@(posedge clk) disable iff (rst)
    push_count == 2'd2 |-> res1.last_of_frame && !res0.last_of_frame)
    else $error("second result of a byte is not the frame status");
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.last_of_frame |-> result_out.result_kind == KindStatus)
    else $error("frame end flag on a sample result");

endmodule
